/* src/xcfr_pkg.sv */
// Shared constants, types and codes for the XOR-checked frame receiver.
`default_nettype none

package xcfr_pkg;

  // Payload store depth and derived widths
  localparam int STORE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd2;

  // Register reset values: '$' opens, '#' closes
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h24;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h23;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NO_SUM   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_DATA,
    S_FIN,
    S_FETCH,
    S_SHOW
  } state_t;

  // Sequencer to store: one write port, one registered read port
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

`default_nettype wire

/* src/xcfr_in_if.sv */
// Receive byte channel: valid/ready with one byte per request.
`default_nettype none

interface xcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/xcfr_out_if.sv */
// Result channel: valid/ready with one frame result per request.
`default_nettype none

interface xcfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] command;
  logic [7:0] data_byte;
  logic [3:0] byte_index;
  logic [3:0] payload_count;
  logic       last;

  modport source (output valid, output status, output command, output data_byte,
                  output byte_index, output payload_count, output last, input ready);
  modport sink   (input valid, input status, input command, input data_byte,
                  input byte_index, input payload_count, input last, output ready);
endinterface

`default_nettype wire

/* src/xcfr_store.sv */
// Payload byte store: one write port, one read port with registered data.
`default_nettype none

module xcfr_store (
  input  wire logic                      clk,
  input  wire xcfr_pkg::store_req_t      req,
  output logic [xcfr_pkg::BYTE_W-1:0]    rd_data
);
  import xcfr_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/xcfr_seq.sv */
// Frame parser and result sequencer: walks the store one entry per read.
`default_nettype none

module xcfr_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  xcfr_in_if.sink                        in_if,
  xcfr_out_if.source                     out_if,
  input  wire logic [xcfr_pkg::BYTE_W-1:0] start_byte,
  input  wire logic [xcfr_pkg::BYTE_W-1:0] end_byte,
  input  wire logic                      check_enable,
  output xcfr_pkg::store_req_t           store_req,
  input  wire logic [xcfr_pkg::BYTE_W-1:0] rd_data
);
  import xcfr_pkg::*;

  state_t            state_r, state_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [BYTE_W-1:0] out_cmd_r, out_cmd_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [IDX_W-1:0]  out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_ready;
  logic              in_take;
  logic              out_free;
  logic              last_entry;
  logic [FILL_W-1:0] count;

  assign in_ready   = (state_r == S_IDLE) || (state_r == S_CMD) || (state_r == S_DATA);
  assign in_take    = in_if.valid && in_ready;
  assign out_free   = !out_valid_r || out_if.ready;
  assign count      = fill_r - FILL_W'(1);
  assign last_entry = (FILL_W'(idx_r) + FILL_W'(2)) == fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= '0;
      fill_r      <= '0;
      xor_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      fill_r      <= fill_nxt;
      xor_r       <= xor_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_data_r   <= out_data_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    fill_nxt       = fill_r;
    xor_nxt        = xor_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_cmd_nxt    = out_cmd_r;
    out_data_nxt   = out_data_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    store_req      = '0;
    store_req.wr_addr = fill_r[ADDR_W-1:0];
    store_req.wr_data = in_if.rx_byte;
    store_req.rd_addr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take && (in_if.rx_byte == start_byte)) begin
          xor_nxt   = start_byte;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (in_take) begin
          cmd_nxt   = in_if.rx_byte;
          xor_nxt   = xor_r ^ in_if.rx_byte;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (in_take) begin
          if (in_if.rx_byte == end_byte) begin
            state_nxt = S_FIN;
          end else if (fill_r < FILL_W'(STORE_DEPTH)) begin
            store_req.wr_en = 1'b1;
            fill_nxt        = fill_r + FILL_W'(1);
            xor_nxt         = xor_r ^ in_if.rx_byte;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_cmd_nxt   = cmd_r;
          out_data_nxt  = '0;
          out_index_nxt = '0;
          out_count_nxt = '0;
          out_last_nxt  = 1'b1;
          if (ovf_r) begin
            out_status_nxt = ST_OVERFLOW;
          end else if (fill_r == '0) begin
            out_status_nxt = ST_NO_SUM;
          end else if (check_enable && (xor_r != '0)) begin
            out_status_nxt = ST_BAD_SUM;
          end else begin
            out_status_nxt = ST_OK;
          end
          if (!ovf_r && (fill_r > FILL_W'(1)) && !(check_enable && (xor_r != '0))) begin
            // Non-empty good frame: stream payload from the store
            idx_nxt   = '0;
            state_nxt = S_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
            fill_nxt      = '0;
            xor_nxt       = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        store_req.rd_en = 1'b1;
        state_nxt       = S_SHOW;
      end
      S_SHOW: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_cmd_nxt    = cmd_r;
          out_data_nxt   = rd_data;
          out_index_nxt  = IDX_W'(idx_r);
          out_count_nxt  = IDX_W'(count);
          out_last_nxt   = last_entry;
          if (last_entry) begin
            fill_nxt  = '0;
            xor_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.command       = out_cmd_r;
  assign out_if.data_byte     = out_data_r;
  assign out_if.byte_index    = out_index_r;
  assign out_if.payload_count = out_count_r;
  assign out_if.last          = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (fill_r == FILL_W'(STORE_DEPTH)))
    else $error("overflow flagged with store not full");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((fill_r == '0) && !ovf_r))
    else $error("frame state not cleared in idle");

  a_fetch_show: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (state_r == S_SHOW))
    else $error("store read not followed by result load");

  a_show_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SHOW) && out_valid_r && !out_if.ready) |=> (state_r == S_SHOW))
    else $error("payload result dropped while output stalled");

endmodule

`default_nettype wire

/* src/xor_checked_frame_receiver.sv */
// Top level of the XOR-checked frame receiver: config registers, parser, store.
`default_nettype none

// Frames arrive as: start, command, payload..., checksum, end. The checksum
// is the XOR of start, command and payload; with check_enable set, a frame
// whose bytes including the checksum do not XOR to zero is rejected.
// in_if: one received byte per request. While a frame is being received
//   (idle, command and data phases) every byte is taken in the cycle it shows.
// out_if: one result per payload byte with status ok, or one error / empty
//   result; last marks the final result of a frame.
// Timing: once the end byte is taken, S_FIN waits for the output register to be
//   free and decides the outcome; a single result is loaded into it directly.
//   Payload results alternate a store read (S_FETCH) with an output register
//   load (S_SHOW); in_ready is low from the end byte until the last is loaded.
// A result waiting in the output register does not block new bytes; only the
//   next frame's end handling waits for the output register to empty.
// A stalled receiver holds the current result and pauses the payload walk.
// cfg_we/cfg_index/cfg_wdata write start_byte, end_byte and check_enable;
//   write only while no frame is in flight. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) restores '$', '#', check on, idle; the
//   store needs no clearing since only entries written in a frame are read.
module xor_checked_frame_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  xcfr_in_if.sink                            in_if,
  xcfr_out_if.source                         out_if,
  input  wire logic                          cfg_we,
  input  wire logic [xcfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [xcfr_pkg::BYTE_W-1:0]   cfg_wdata
);
  import xcfr_pkg::*;

  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] end_byte_r;
  logic              check_enable_r;
  store_req_t        store_req;
  logic [BYTE_W-1:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= START_BYTE_RST;
      end_byte_r     <= END_BYTE_RST;
      check_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE:   start_byte_r   <= cfg_wdata;
        CFG_END_BYTE:     end_byte_r     <= cfg_wdata;
        CFG_CHECK_ENABLE: check_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Parser, checksum and result sequencer
  xcfr_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .out_if       (out_if),
    .start_byte   (start_byte_r),
    .end_byte     (end_byte_r),
    .check_enable (check_enable_r),
    .store_req    (store_req),
    .rd_data      (rd_data)
  );

  // Payload byte store
  xcfr_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

/* bench/xor_checked_frame_receiver_tb.sv */
// Self-checking bench for the XOR-checked frame receiver: byte stream in, frame results out.
`default_nettype none

module xor_checked_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xcfr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;    // covers the payload walk plus slack
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off under pressure
  localparam int MAX_REPORTS   = 10;

  // Index past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum {SINK_FREE, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [IDX_W-1:0]  payload_count;
    logic              last;
  } frame_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  xcfr_in_if  in_bus ();
  xcfr_out_if out_bus ();

  xor_checked_frame_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes waiting to be offered, and results the parser shadow says must come.
  logic [BYTE_W-1:0] pending_bytes[$];
  frame_result_t     expected_results[$];

  // Shadow of the register file, kept in step with every cfg write.
  logic [BYTE_W-1:0] start_code = START_BYTE_RST;
  logic [BYTE_W-1:0] end_code   = END_BYTE_RST;
  logic              check_on   = 1'b1;

  // Shadow of the parser.
  state_t            parse_phase  = S_IDLE;
  logic [BYTE_W-1:0] frame_cmd    = '0;
  logic [BYTE_W-1:0] shadow_store[STORE_DEPTH];
  int                stored_count = 0;
  logic [BYTE_W-1:0] frame_xor    = '0;
  logic              dropped      = 1'b0;

  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         burst_left     = 1;
  int         gap_left       = 0;
  bit         steady_feed    = 1'b0;
  sink_mode_t sink_mode      = SINK_FREE;
  bit         hold_armed     = 1'b0;
  bit         hold_done      = 1'b0;
  int         hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: consumes one accepted byte, queues the results it causes.
  // ---------------------------------------------------------------------------
  function automatic void emit(status_t st, logic [BYTE_W-1:0] d, logic [IDX_W-1:0] idx,
                               logic [IDX_W-1:0] cnt, logic lst);
    frame_result_t r;
    r.status        = st;
    r.command       = frame_cmd;
    r.data_byte     = d;
    r.byte_index    = idx;
    r.payload_count = cnt;
    r.last          = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void absorb_rx_byte(logic [BYTE_W-1:0] b);
    int n;
    if (parse_phase == S_IDLE) begin
      // anything but the start byte is line noise here
      if (b == start_code) begin
        parse_phase = S_CMD;
        frame_xor   = start_code;
      end
    end else if (parse_phase == S_CMD) begin
      // byte after start is always the command, even start/end values
      frame_cmd   = b;
      frame_xor   = frame_xor ^ b;
      parse_phase = S_DATA;
    end else if (b != end_code) begin
      // a start byte in here is just data
      if (stored_count < STORE_DEPTH) begin
        shadow_store[stored_count] = b;
        stored_count++;
        frame_xor = frame_xor ^ b;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      // end byte: one error or empty result, or one ok result per payload byte
      if (dropped) begin
        emit(ST_OVERFLOW, '0, '0, '0, 1'b1);
      end else if (stored_count == 0) begin
        emit(ST_NO_SUM, '0, '0, '0, 1'b1);
      end else if (check_on && frame_xor != '0) begin
        // checksum byte is folded in, so a good frame XORs to zero
        emit(ST_BAD_SUM, '0, '0, '0, 1'b1);
      end else begin
        n = stored_count - 1;
        if (n == 0) begin
          emit(ST_OK, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            emit(ST_OK, shadow_store[i], IDX_W'(i), IDX_W'(n), (i == n - 1));
          end
        end
      end
      parse_phase  = S_IDLE;
      stored_count = 0;
      frame_xor    = '0;
      dropped      = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Mostly short frames, some long, a few past the store depth.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(0, 4);
    if (r < 18) return $urandom_range(5, 15);
    return $urandom_range(16, 18);
  endfunction

  // Well-formed frame with random payload; good_sum=0 corrupts the checksum.
  // Returns the number of bytes queued.
  function automatic int queue_frame(int len, bit good_sum);
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] p;
    logic [BYTE_W-1:0] body[$];
    do begin
      body.delete();
      cmd = 8'($urandom_range(0, 255));
      sum = start_code ^ cmd;
      for (int i = 0; i < len; i++) begin
        do p = 8'($urandom_range(0, 255)); while (p == end_code);
        body.push_back(p);
        sum = sum ^ p;
      end
      if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
    end while (sum == end_code);  // checksum equal to end would close early
    pending_bytes.push_back(start_code);
    pending_bytes.push_back(cmd);
    foreach (body[i]) pending_bytes.push_back(body[i]);
    pending_bytes.push_back(sum);
    pending_bytes.push_back(end_code);
    return len + 4;
  endfunction

  function automatic void queue_random(int target);
    int added;
    int pick;
    int k;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        added += queue_frame(pick_len(), 1'b1);
      end else if (pick == 7) begin
        added += queue_frame(pick_len(), 1'b0);
      end else if (pick == 8) begin
        // line noise; mostly ignored, not counted
        k = $urandom_range(1, 3);
        repeat (k) pending_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // broken frame: random body, end byte sometimes missing
        pending_bytes.push_back(start_code);
        pending_bytes.push_back(8'($urandom_range(0, 255)));
        k = $urandom_range(0, 4);
        repeat (k) pending_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) != 0) pending_bytes.push_back(end_code);
        added += k + 3;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Control helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_START_BYTE:   start_code = val;
      CFG_END_BYTE:     end_code   = val;
      CFG_CHECK_ENABLE: check_on   = val[0];
      default: ;
    endcase
  endtask

  // Wait for all requests and results, close any half-open frame, then let
  // the block finish its payload walk before anything else touches it.
  task automatic settle();
    do begin
      do @(negedge clk); while (pending_bytes.size() != 0 || expected_results.size() != 0);
      if (parse_phase == S_CMD) pending_bytes.push_back(8'h00);
      if (parse_phase != S_IDLE) pending_bytes.push_back(end_code);
    end while (pending_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid   <= 1'b0;
      in_bus.rx_byte <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        void'(pending_bytes.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          if (steady_feed || $urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 12);
        end
      end
      if (in_bus.valid && !in_bus.ready) begin
        // request still open: hold byte and valid
      end else if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= pending_bytes[0];
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Feed every accepted byte to the parser shadow.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) absorb_rx_byte(in_bus.rx_byte);
  end

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern plus one long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_FREE:    out_bus.ready <= 1'b1;
        SINK_RANDOM:  out_bus.ready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: out_bus.ready <= ((cycle_count % 7) >= 3);
        default:      out_bus.ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void report_mismatch(string what, frame_result_t want, frame_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch (%s) cycle %0d: expected st=%0d cmd=%h data=%h idx=%0d cnt=%0d last=%0d,",
               what, cycle_count, want.status, want.command, want.data_byte, want.byte_index,
               want.payload_count, want.last,
               " got st=%0d cmd=%h data=%h idx=%0d cnt=%0d last=%0d",
               got.status, got.command, got.data_byte, got.byte_index,
               got.payload_count, got.last);
  endfunction

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.status        = status_t'(out_bus.status);
      got.command       = out_bus.command;
      got.data_byte     = out_bus.data_byte;
      got.byte_index    = out_bus.byte_index;
      got.payload_count = out_bus.payload_count;
      got.last          = out_bus.last;
      if (expected_results.size() == 0) begin
        report_mismatch("no result pending", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (want.status != got.status || want.command != got.command ||
            want.data_byte != got.data_byte || want.byte_index != got.byte_index ||
            want.payload_count != got.payload_count || want.last != got.last)
          report_mismatch("field", want, got);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [BYTE_W-1:0] directed[];

    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_START_BYTE;
    cfg_wdata      = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset registers ('$' opens, '#' closes, check on).
    //   noise 00/FF outside a frame: ignored
    //   end byte as command, then end with nothing stored: no-checksum error
    //   start byte as command and inside payload, payload 00/FF: ok x3
    //   empty payload with good checksum: single empty ok
    //   corrupt checksum: checksum error
    directed = '{8'hFF, 8'h00,
                 START_BYTE_RST, END_BYTE_RST, END_BYTE_RST,
                 START_BYTE_RST, START_BYTE_RST, 8'h00, 8'hFF, START_BYTE_RST, 8'hDB,
                 END_BYTE_RST,
                 START_BYTE_RST, 8'h5A, 8'h7E, END_BYTE_RST,
                 START_BYTE_RST, 8'h11, 8'h22, 8'h55, END_BYTE_RST};
    sink_mode = SINK_FREE;
    foreach (directed[i]) pending_bytes.push_back(directed[i]);
    settle();

    // Reset registers, random traffic; largest payload and an overflow up front.
    sink_mode = SINK_RANDOM;
    void'(queue_frame(15, 1'b1));
    void'(queue_frame(17, 1'b1));
    queue_random(45);
    settle();

    // Low start, high end, checksum ignored.
    write_reg(CFG_START_BYTE, 8'h00);
    write_reg(CFG_END_BYTE, 8'hFF);
    write_reg(CFG_CHECK_ENABLE, 8'h00);
    @(negedge clk);
    sink_mode = SINK_PATTERN;
    queue_random(45);
    settle();

    // High start, low end, check on; receiver holds off while bytes keep
    // coming so the output backs up into the input.
    write_reg(CFG_START_BYTE, 8'hFF);
    write_reg(CFG_END_BYTE, 8'h00);
    write_reg(CFG_CHECK_ENABLE, 8'h01);
    @(negedge clk);
    sink_mode   = SINK_RANDOM;
    steady_feed = 1'b1;
    queue_random(45);
    hold_armed  = 1'b1;
    settle();

    // Start and end share one value; no idling on either side.
    write_reg(CFG_START_BYTE, 8'h7E);
    write_reg(CFG_END_BYTE, 8'h7E);
    @(negedge clk);
    sink_mode = SINK_FREE;
    queue_random(30);
    settle();

    // Back to defaults via writes; out-of-range index must not disturb anything.
    steady_feed = 1'b0;
    write_reg(CFG_UNUSED, 8'hA5);
    write_reg(CFG_START_BYTE, START_BYTE_RST);
    write_reg(CFG_END_BYTE, END_BYTE_RST);
    @(negedge clk);
    sink_mode = SINK_PATTERN;
    queue_random(30);
    settle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
